// ===== rtl/fim_pkg.sv =====
// ----------------------------------------------------------------------------
// fim_pkg: shared definitions for the frame interval monitor
// Field widths, reset values and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package fim_pkg;

    localparam int TS_W              = 48;
    localparam int IV_W              = 32;
    localparam int RATE_W            = 32;
    localparam int HELD_W            = 7;
    localparam int WIN_TICKS_W       = IV_W + 1;
    localparam int HISTORY_DEPTH_DEF = 64;

    localparam logic [IV_W-1:0] TPS_RESET = 32'd10000000;

    // Commands from the controller; each enables one step of the datapath.
    typedef struct packed {
        logic capture;    // take the timestamp of an accepted transfer
        logic calc;       // form the saturated interval
        logic gate;       // outlier gate, window update, history read
        logic update;     // history write, sum and count update
        logic div_load;   // load the serial divider
        logic div_step;   // one quotient bit
        logic out_load;   // load the result register and the average
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;   // the divider is on its final quotient bit
    } t_dp_status;

endpackage

// ===== rtl/fim_ctrl.sv =====
// ----------------------------------------------------------------------------
// fim_ctrl: sequencing controller of the frame interval monitor
// Steps each accepted item through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module fim_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  fim_pkg::t_dp_status   i_status,
    output fim_pkg::t_dp_cmd      o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_GATE  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_DLOAD = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.capture  = i_in_valid && (r_state == ST_IDLE);
        o_cmd.calc     = (r_state == ST_CALC);
        o_cmd.gate     = (r_state == ST_GATE);
        o_cmd.update   = (r_state == ST_UPD);
        o_cmd.div_load = (r_state == ST_DLOAD);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.out_load = (r_state == ST_DONE) && out_free;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_CALC;
            ST_CALC:  n_state = ST_GATE;
            ST_GATE:  n_state = ST_UPD;
            ST_UPD:   n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV:   if (i_status.div_last) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/fim_datapath.sv =====
// ----------------------------------------------------------------------------
// fim_datapath: arithmetic and storage of the frame interval monitor
// Interval, outlier gate, interval history, rate window and serial divider.
// ----------------------------------------------------------------------------
module fim_datapath #(
    parameter int HISTORY_DEPTH = fim_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fim_pkg::t_dp_cmd             i_cmd,
    output fim_pkg::t_dp_status          o_status,
    input  logic                         i_cfg_wr,
    input  logic [fim_pkg::IV_W-1:0]     i_cfg_data,
    input  logic [fim_pkg::TS_W-1:0]     i_frame_timestamp,
    output logic [fim_pkg::IV_W-1:0]     o_average_interval,
    output logic [fim_pkg::RATE_W-1:0]   o_frame_rate,
    output logic [fim_pkg::HELD_W-1:0]   o_samples_held
);

    localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int SW     = fim_pkg::IV_W + AW;
    localparam int STEP_W = $clog2(SW);
    localparam int IV_W   = fim_pkg::IV_W;
    localparam int WT_W   = fim_pkg::WIN_TICKS_W;

    logic [IV_W-1:0]            r_tps;
    logic [fim_pkg::TS_W-1:0]   r_prev_ts;
    logic [fim_pkg::TS_W-1:0]   r_ts;
    logic [IV_W-1:0]            r_interval;
    logic                       r_pass;
    logic [IV_W-1:0]            r_old;
    logic [AW-1:0]              r_slot;
    logic [CW-1:0]              r_count;
    logic [SW-1:0]              r_sum;
    logic [IV_W-1:0]            r_avg;
    logic [fim_pkg::RATE_W-1:0] r_win_frames;
    logic [WT_W-1:0]            r_win_ticks;
    logic [fim_pkg::RATE_W-1:0] r_rate;
    logic [CW-1:0]              r_rem;
    logic [SW-1:0]              r_quot;
    logic [STEP_W-1:0]          r_step;

    logic [IV_W-1:0]            mem [HISTORY_DEPTH];

    logic [fim_pkg::TS_W-1:0]   diff;
    logic [IV_W-1:0]            interval_sat;
    logic [IV_W-1:0]            gap;
    logic [AW-1:0]              next_slot;
    logic                       full;
    logic [fim_pkg::RATE_W-1:0] frames_inc;
    logic [WT_W-1:0]            ticks_inc;
    logic [CW:0]                trial;
    logic                       q_bit;
    logic [IV_W-1:0]            avg_new;

    assign diff         = r_ts - r_prev_ts;
    assign interval_sat = (|diff[fim_pkg::TS_W-1:IV_W]) ? '1 : diff[IV_W-1:0];
    assign gap          = (r_interval >= r_avg) ? (r_interval - r_avg) : (r_avg - r_interval);
    assign next_slot    = (r_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign full         = (r_count == CW'(HISTORY_DEPTH));
    assign frames_inc   = r_win_frames + 1'b1;
    assign ticks_inc    = r_win_ticks + WT_W'(r_interval);

    // Restoring division: shift in one dividend bit, subtract when it fits.
    assign trial   = {r_rem, r_quot[SW-1]};
    assign q_bit   = (trial >= {1'b0, r_count});
    assign avg_new = (r_count == '0) ? '0 : r_quot[IV_W-1:0];

    assign o_status.div_last = (r_step == STEP_W'(SW - 1));

    // History memory; the entry about to be overwritten is read in the gate step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && r_pass) begin
            mem[next_slot] <= r_interval;
        end
        if (i_cmd.gate) begin
            r_old <= mem[next_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ts <= i_frame_timestamp;
        end
        if (i_cmd.calc) begin
            r_interval <= interval_sat;
        end
        if (i_cmd.gate) begin
            r_pass <= (gap < r_tps);
        end
        if (i_cmd.div_load) begin
            r_quot <= r_sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[SW-2:0], q_bit};
            r_rem  <= q_bit ? CW'(trial - {1'b0, r_count}) : trial[CW-1:0];
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.out_load) begin
            o_average_interval <= avg_new;
            o_frame_rate       <= r_rate;
            o_samples_held     <= fim_pkg::HELD_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= fim_pkg::TPS_RESET;
            r_prev_ts    <= '0;
            r_slot       <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_avg        <= '0;
            r_win_frames <= '0;
            r_win_ticks  <= '0;
            r_rate       <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_tps <= i_cfg_data;
            end
            if (i_cmd.calc) begin
                r_prev_ts <= r_ts;
            end
            if (i_cmd.gate) begin
                if (ticks_inc > WT_W'(r_tps)) begin
                    r_rate       <= frames_inc;
                    r_win_frames <= '0;
                    r_win_ticks  <= '0;
                end else begin
                    r_win_frames <= frames_inc;
                    r_win_ticks  <= ticks_inc;
                end
            end
            if (i_cmd.update && r_pass) begin
                r_slot <= next_slot;
                if (full) begin
                    r_sum <= r_sum + SW'(r_interval) - SW'(r_old);
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + SW'(r_interval);
                end
            end
            if (i_cmd.out_load) begin
                r_avg <= avg_new;
            end
        end
    end

endmodule

// ===== rtl/frame_interval_monitor_top.sv =====
// Divider: a serial divider forms one quotient bit per cycle over the history
//   sum, which is SW = 32 + clog2(HISTORY_DEPTH) bits wide (38 at depth 64).
// A new transfer is taken only once the previous result has been loaded into
//   the output register.
// Reset: synchronous, active low; the control state, output valid, history slot,
//   count and sum, the average and the rate clear, and the one-second threshold returns to 10000000 ticks.
// ----------------------------------------------------------------------------
// frame_interval_monitor_top: frame interval averaging and frame-rate counter
// Takes frame-end timestamps, keeps a moving average of the frame interval
// over a history of recent intervals and counts frames per second.
// ----------------------------------------------------------------------------
//
// Each frame-end timestamp arrives as one input transfer. The controller then
// walks the datapath through a fixed sequence of steps:
//   1. The interval since the previous timestamp is formed modulo 2^48 and
//      saturated to 32 bits.
//   2. The interval is compared against the current average. When it lies
//      within one second (ticks_per_second) of it, it is accepted into the
//      history. In the same step the one-second rate window is advanced, and
//      the history entry that a full history will drop is read.
//   3. An accepted interval is written into the history ring, and the running
//      sum and sample count are updated.
//   4. A restoring serial divider forms sum / count, one bit per cycle.
//   5. The new average, the latched rate and the sample count are loaded into
//      the output register.
// The output register separates the two sides, so a new transfer is taken as
// soon as the result is loaded, even if the consumer has not yet taken it.
// The configuration channel is always ready; it is to be written while idle, which the block itself does not enforce.
module frame_interval_monitor_top #(
    parameter int HISTORY_DEPTH = fim_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [fim_pkg::TS_W-1:0]     i_frame_timestamp,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fim_pkg::IV_W-1:0]     o_average_interval,
    output logic [fim_pkg::RATE_W-1:0]   o_frame_rate,
    output logic [fim_pkg::HELD_W-1:0]   o_samples_held,
    // Configuration channel: ticks_per_second.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fim_pkg::IV_W-1:0]     i_cfg_ticks_per_second
);

    fim_pkg::t_dp_cmd    cmd;
    fim_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    fim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fim_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_wr           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data         (i_cfg_ticks_per_second),
        .i_frame_timestamp  (i_frame_timestamp),
        .o_average_interval (o_average_interval),
        .o_frame_rate       (o_frame_rate),
        .o_samples_held     (o_samples_held)
    );

endmodule
